### hw/rtl/evg_pkg.sv
package evg_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int NODES_PER_HEX  = 8;
	localparam int NODES_PER_QUAD = 4;
	localparam int ACC_W          = 64;
	localparam int RSUM_W         = 36;
	localparam int CNT_W          = 5;
	localparam int DIV_W          = 31;
	localparam int N_LANES        = 9;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_COUNT = 2'd1;
	localparam logic [1:0] ERR_ZERO  = 2'd2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [RSUM_W-1:0] RSUM_MAX = {1'b0, {(RSUM_W-1){1'b1}}};
	localparam logic signed [RSUM_W-1:0] RSUM_MIN = {1'b1, {(RSUM_W-1){1'b0}}};

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] divisor;
	} div_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

### hw/rtl/evg_lane.sv
// One accumulator lane: saturating multiply-accumulate of vel*b, then a
// restoring divide of the 64-bit sum by the element divisor, one bit a cycle.
module evg_lane import evg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    acc_en,
	input  logic                    clear,
	input  logic signed [31:0]      a,
	input  logic signed [31:0]      b,
	input  div_ctl_t                ctl,
	output logic signed [31:0]      quot,
	output logic                    done
);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] prod_s1;
	logic                    prod_v_s1;
	logic [ACC_W-1:0]        mag_q;
	logic [ACC_W-1:0]        qt_q;
	logic [DIV_W:0]          rem_q;
	logic [DIV_W-1:0]        den_q;
	logic                    neg_q;
	logic [6:0]              bit_q;
	logic                    run_q;
	logic signed [ACC_W:0]   sum;
	logic [DIV_W+1:0]        trial;
	logic signed [ACC_W:0]   sq;

	assign sum = {acc_q[ACC_W-1], acc_q} + {prod_s1[ACC_W-1], prod_s1};
	assign trial = {rem_q, mag_q[ACC_W-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			prod_v_s1 <= 1'b0;
			run_q     <= 1'b0;
			bit_q     <= '0;
			done      <= 1'b0;
		end else begin
			prod_v_s1 <= acc_en;
			done      <= 1'b0;
			if (clear) begin
				acc_q <= '0;
			end else if (prod_v_s1) begin
				if (sum > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) begin
					acc_q <= ACC_MAX;
				end else if (sum < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) begin
					acc_q <= ACC_MIN;
				end else begin
					acc_q <= sum[ACC_W-1:0];
				end
			end
			if (ctl.start) begin
				run_q <= 1'b1;
				bit_q <= 7'(ACC_W);
			end else if (run_q) begin
				bit_q <= bit_q - 7'd1;
				if (bit_q == 7'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ACC_W'(a * b);
		if (ctl.start) begin
			neg_q <= acc_q[ACC_W-1];
			mag_q <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
			rem_q <= '0;
			qt_q  <= '0;
			den_q <= ctl.divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[ACC_W-2:0], 1'b0};
			if (!trial[DIV_W+1]) begin
				rem_q <= trial[DIV_W:0];
				qt_q  <= {qt_q[ACC_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W-1:0], mag_q[ACC_W-1]};
				qt_q  <= {qt_q[ACC_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({1'b0, qt_q}) : $signed({1'b0, qt_q});
		if (sq > 65'sd2147483647) begin
			quot = 32'sh7fffffff;
		end else if (sq < -65'sd2147483648) begin
			quot = 32'sh80000000;
		end else begin
			quot = sq[31:0];
		end
	end

endmodule

### hw/rtl/evg_radial.sv
// Radial term: sign(s)*floor(|s|*area/(4*vol)), saturated. Multiply first
// (exact, 67 bits), then a serial divide by 4*vol.
module evg_radial import evg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [RSUM_W-1:0] rsum,
	input  logic [DIV_W-1:0]         area,
	input  logic [DIV_W-1:0]         vol,
	output logic signed [31:0]       term,
	output logic                     done
);

	localparam int P_W = RSUM_W + DIV_W;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_MUL  = 4'b0010,
		PH_SUM  = 4'b0100,
		PH_DIV  = 4'b1000
	} phase_t;

	logic [P_W-1:0]     mag_q;
	logic [P_W-1:0]     qt_q;
	logic [DIV_W+2:0]   rem_q;
	logic [DIV_W+2:0]   den_q;
	logic               neg_q;
	logic [6:0]         bit_q;
	phase_t             ph_q;
	logic [RSUM_W-1:0]  abs_q;
	logic [P_W-1:0]     plo_q;
	logic [P_W-1:0]     phi_q;
	logic [DIV_W+3:0]   trial;
	logic [P_W-1:0]     clip;

	assign trial = {rem_q, mag_q[P_W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			bit_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				ph_q <= PH_MUL;
			end else if (ph_q == PH_MUL) begin
				ph_q <= PH_SUM;
			end else if (ph_q == PH_SUM) begin
				ph_q  <= PH_DIV;
				bit_q <= 7'(P_W);
			end else if (ph_q == PH_DIV) begin
				bit_q <= bit_q - 7'd1;
				if (bit_q == 7'd1) begin
					ph_q <= PH_IDLE;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= rsum[RSUM_W-1];
			abs_q <= rsum[RSUM_W-1] ? RSUM_W'(-rsum) : rsum;
			den_q <= {vol, 2'b00};
		end else if (ph_q == PH_MUL) begin
			// split the product in two narrow multiplies
			plo_q <= P_W'(abs_q[17:0] * area);
			phi_q <= P_W'(abs_q[RSUM_W-1:18] * area);
		end else if (ph_q == PH_SUM) begin
			mag_q <= plo_q + (phi_q << 18);
			rem_q <= '0;
			qt_q  <= '0;
		end else if (ph_q == PH_DIV) begin
			mag_q <= {mag_q[P_W-2:0], 1'b0};
			if (!trial[DIV_W+3]) begin
				rem_q <= trial[DIV_W+2:0];
				qt_q  <= {qt_q[P_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DIV_W+1:0], mag_q[P_W-1]};
				qt_q  <= {qt_q[P_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		clip = (qt_q > P_W'(64'h1_0000_0000)) ? P_W'(64'h1_0000_0000) : qt_q;
		if (neg_q) begin
			term = (clip >= P_W'(64'h8000_0000)) ? 32'sh80000000 : -$signed(clip[31:0]);
		end else begin
			term = (clip >= P_W'(64'h8000_0000)) ? 32'sh7fffffff : $signed(clip[31:0]);
		end
	end

endmodule

### hw/rtl/element_velocity_gradient.sv
// Channel   Handshake            Payload
// cfg       cfg_valid/cfg_ready  cfg_data (planar_mode)
// node in   start/busy           vel_*, b_*, elem_volume, quad_area, last_node
// entry out strobe               row, col, grad_value, sym_part, antisym_part,
//                                divergence, error_code, last_entry
// A non-last node holds busy through the accumulate state (ST_ACC) only.
// A last node holds busy through accumulate, check, the divide (64 quotient bits
// per lane; in 2D the radial divide of 67 bits is the longer) and the nine output
// entries. A count or zero-divisor error skips the divide.
// Reset clears accumulators, counter and mode. The receiver cannot stall:
// one entry leaves each cycle with strobe high.
module element_velocity_gradient import evg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic [30:0]        elem_volume,
	input  logic [30:0]        quad_area,
	input  logic               last_node,
	output logic               strobe,
	output logic [1:0]         row,
	output logic [1:0]         col,
	output logic signed [31:0] grad_value,
	output logic signed [31:0] sym_part,
	output logic signed [31:0] antisym_part,
	output logic signed [31:0] divergence,
	output logic [1:0]         error_code,
	output logic               last_entry
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ACC  = 5'b00010,
		ST_LAST = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic planar_q, mode_q, last_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [RSUM_W-1:0] rsum_q;
	logic [1:0] err_q;
	logic [DIV_W-1:0] vol_q, area_q;
	logic [3:0] k_q;
	logic acc_en, clear_el, div_go;
	logic signed [31:0] va [3];
	logic signed [31:0] vb [3];
	logic signed [31:0] lq [N_LANES];
	logic [N_LANES-1:0] ldone;
	logic signed [31:0] rterm;
	logic rdone, ldone_q, rdone_q;
	logic signed [31:0] L_q [N_LANES];
	logic signed [31:0] dv_q;
	logic signed [RSUM_W:0] rnext;
	div_ctl_t ctl;
	logic [1:0] err_n;
	logic signed [ACC_W-1:0] tr;
	logic signed [32:0] ga, gt, sp, sm;

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign acc_en = start && !busy;
	assign va[0] = vel_x;
	assign va[1] = vel_y;
	assign va[2] = planar_q ? 32'sd0 : vel_z;
	assign vb[0] = b_x;
	assign vb[1] = b_y;
	assign vb[2] = planar_q ? 32'sd0 : b_z;
	assign rnext = {rsum_q[RSUM_W-1], rsum_q} + (RSUM_W+1)'(vel_y);

	always_comb begin
		err_n = ERR_OK;
		if (cnt_q != (mode_q ? CNT_W'(NODES_PER_QUAD) : CNT_W'(NODES_PER_HEX))) begin
			err_n = ERR_COUNT;
		end else if (vol_q == '0 || (mode_q && area_q == '0)) begin
			err_n = ERR_ZERO;
		end
	end

	assign div_go = (state_q == ST_LAST) && (err_n == ERR_OK);
	assign ctl.start = div_go;
	assign ctl.divisor = mode_q ? area_q : vol_q;
	assign clear_el = (state_q == ST_OUT) && (k_q == 4'd8);

	for (genvar g = 0; g < N_LANES; g++) begin : g_lane
		evg_lane u_lane (
			.clk(clk), .arst_n(arst_n), .acc_en(acc_en), .clear(clear_el),
			.a(va[g / 3]), .b(vb[g % 3]), .ctl(ctl), .quot(lq[g]), .done(ldone[g])
		);
	end

	evg_radial u_radial (
		.clk(clk), .arst_n(arst_n), .start(div_go), .rsum(rsum_q),
		.area(area_q), .vol(vol_q), .term(rterm), .done(rdone)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			planar_q <= 1'b0;
			mode_q   <= 1'b0;
			last_q   <= 1'b0;
			cnt_q    <= '0;
			rsum_q   <= '0;
			err_q    <= ERR_OK;
			vol_q    <= '0;
			area_q   <= '0;
			k_q      <= '0;
			ldone_q  <= 1'b0;
			rdone_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				planar_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_en) begin
						mode_q <= planar_q;
						last_q <= last_node;
						vol_q  <= elem_volume;
						area_q <= quad_area;
						if (cnt_q != '1) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (planar_q) begin
							if (rnext > $signed({RSUM_MAX[RSUM_W-1], RSUM_MAX})) begin
								rsum_q <= RSUM_MAX;
							end else if (rnext < $signed({RSUM_MIN[RSUM_W-1], RSUM_MIN})) begin
								rsum_q <= RSUM_MIN;
							end else begin
								rsum_q <= rnext[RSUM_W-1:0];
							end
						end
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					// lanes add the product of this node at the end of this cycle
					state_q <= last_q ? ST_LAST : ST_IDLE;
				end
				ST_LAST: begin
					// accumulators hold the final node here
					err_q   <= err_n;
					ldone_q <= 1'b0;
					rdone_q <= !mode_q;
					state_q <= (err_n == ERR_OK) ? ST_DIV : ST_OUT;
					k_q     <= '0;
				end
				ST_DIV: begin
					if (&ldone) begin
						ldone_q <= 1'b1;
					end
					if (rdone) begin
						rdone_q <= 1'b1;
					end
					if (ldone_q && rdone_q) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'd8) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
						rsum_q  <= '0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// latch the tensor once the lane dividers (and in 2D the radial one) finish; zero on error
	always_ff @(posedge clk) begin
		if (state_q == ST_LAST && err_n != ERR_OK) begin
			for (int i = 0; i < N_LANES; i++) begin
				L_q[i] <= '0;
			end
			dv_q <= '0;
		end else if (state_q == ST_DIV && ldone_q && rdone_q) begin
			for (int i = 0; i < N_LANES; i++) begin
				if (mode_q && (i == 2 || i == 5 || i == 6 || i == 7)) begin
					L_q[i] <= '0;
				end else if (mode_q && i == 8) begin
					L_q[i] <= rterm;
				end else begin
					L_q[i] <= lq[i];
				end
			end
			dv_q <= sat32(tr);
		end
	end

	assign tr = ACC_W'(lq[0]) + ACC_W'(lq[4]) + (mode_q ? ACC_W'(rterm) : ACC_W'(lq[8]));

	always_comb begin
		logic [3:0] kt;
		kt = (k_q >= 4'd6) ? 4'(k_q - 4'd6) :
		     (k_q >= 4'd3) ? 4'(k_q - 4'd3) : k_q;
		row = (k_q >= 4'd6) ? 2'd2 : (k_q >= 4'd3) ? 2'd1 : 2'd0;
		col = kt[1:0];
		ga = 33'(L_q[k_q]);
		gt = 33'(L_q[4'(kt * 4'd3) + 4'(row)]);
		sp = ga + gt;
		sm = ga - gt;
		grad_value   = L_q[k_q];
		sym_part     = 32'(sp >>> 1);
		antisym_part = 32'(sm >>> 1);
	end

	assign strobe = (state_q == ST_OUT);
	assign divergence = dv_q;
	assign error_code = err_q;
	assign last_entry = (k_q == 4'd8);

	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("strobe while idle");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_entry) |=> !strobe) else $error("extra entry");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last_entry) |=> (strobe && k_q == $past(k_q) + 4'd1))
		else $error("entry gap");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && error_code != ERR_OK) |-> (grad_value == 32'sd0))
		else $error("nonzero on error");

endmodule

### dv/element_velocity_gradient_tb.sv
`timescale 1ns / 100ps

module element_velocity_gradient_tb import evg_pkg::*; ();

	typedef struct {
		logic signed [31:0] vx, vy, vz, bx, by, bz;
		logic [30:0] vol, area;
		logic last;
	} node_t;

	typedef struct {
		logic [1:0] row, col;
		logic signed [31:0] grad, sym, anti, dv;
		logic [1:0] err;
		logic last;
	} entry_t;

	class grad_scoreboard;
		longint acc[9];
		longint rsum;
		int unsigned nodes;
		bit planar;
		entry_t pending[$];
		int unsigned fails;

		function void clear_element();
			foreach (acc[k]) acc[k] = 0;
			rsum = 0;
			nodes = 0;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint add_sat(longint a, longint b);
			longint s;
			s = a + b;
			if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? ACC_MIN : ACC_MAX;
			return s;
		endfunction

		function longint halve(longint s);
			return (s < 0 ? s - 1 : s) / 2;
		endfunction

		function longint radial(longint sum, longint unsigned area, longint unsigned vol);
			longint unsigned mag, den, whole, rem, q;
			mag = sum < 0 ? longint'(-sum) : sum;
			den = 4 * vol;
			whole = mag / den;
			rem = mag % den;
			if (whole >= 64'h1_0000_0000) begin
				q = 64'h1_0000_0000;
			end else begin
				q = whole * area + (rem * area) / den;
				if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
			end
			return sum < 0 ? clamp32(-longint'(q)) : clamp32(longint'(q));
		endfunction

		// accumulate one accepted node; on the last one queue nine entries
		function void note_node(node_t n);
			longint v[3], b[3], l[9], r, dv;
			longint unsigned vol, area;
			logic [1:0] err;
			int unsigned want;
			entry_t e;
			v[0] = n.vx; v[1] = n.vy; v[2] = planar ? 0 : longint'(n.vz);
			b[0] = n.bx; b[1] = n.by; b[2] = planar ? 0 : longint'(n.bz);
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					acc[3*i+j] = add_sat(acc[3*i+j], v[i] * b[j]);
			if (planar) begin
				r = rsum + v[1];
				if (r > longint'(RSUM_MAX)) r = RSUM_MAX;
				if (r < longint'(RSUM_MIN)) r = RSUM_MIN;
				rsum = r;
			end
			if (nodes < 31) nodes++;
			if (!n.last) return;
			vol = n.vol;
			area = n.area;
			want = planar ? NODES_PER_QUAD : NODES_PER_HEX;
			err = ERR_OK;
			if (nodes != want) err = ERR_COUNT;
			else if (planar ? (area == 0 || vol == 0) : (vol == 0)) err = ERR_ZERO;
			foreach (l[k]) l[k] = 0;
			if (err == ERR_OK) begin
				if (!planar) begin
					foreach (l[k]) l[k] = clamp32(acc[k] / longint'(vol));
				end else begin
					l[0] = clamp32(acc[0] / longint'(area));
					l[1] = clamp32(acc[1] / longint'(area));
					l[3] = clamp32(acc[3] / longint'(area));
					l[4] = clamp32(acc[4] / longint'(area));
					l[8] = radial(rsum, area, vol);
				end
			end
			dv = clamp32(l[0] + l[4] + l[8]);
			for (int k = 0; k < 9; k++) begin
				e.row = 2'(k / 3);
				e.col = 2'(k % 3);
				e.grad = 32'(l[k]);
				e.sym = 32'(halve(l[k] + l[3*(k%3) + k/3]));
				e.anti = 32'(halve(l[k] - l[3*(k%3) + k/3]));
				e.dv = 32'(dv);
				e.err = err;
				e.last = (k == 8);
				pending.push_back(e);
			end
			clear_element();
		endfunction

		function void check_entry(entry_t a);
			entry_t x;
			if (pending.size() == 0) begin
				$error("unexpected entry row %0d col %0d", a.row, a.col);
				fails++;
				return;
			end
			x = pending.pop_front();
			if (a.row !== x.row) begin
				$error("row: expected %0d, got %0d", x.row, a.row); fails++;
			end
			if (a.col !== x.col) begin
				$error("col: expected %0d, got %0d", x.col, a.col); fails++;
			end
			if (a.grad !== x.grad) begin
				$error("grad_value: expected %0d, got %0d", x.grad, a.grad); fails++;
			end
			if (a.sym !== x.sym) begin
				$error("sym_part: expected %0d, got %0d", x.sym, a.sym); fails++;
			end
			if (a.anti !== x.anti) begin
				$error("antisym_part: expected %0d, got %0d", x.anti, a.anti); fails++;
			end
			if (a.dv !== x.dv) begin
				$error("divergence: expected %0d, got %0d", x.dv, a.dv); fails++;
			end
			if (a.err !== x.err) begin
				$error("error_code: expected %0d, got %0d", x.err, a.err); fails++;
			end
			if (a.last !== x.last) begin
				$error("last_entry: expected %0d, got %0d", x.last, a.last); fails++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready, cfg_data;
	logic start, busy;
	logic signed [31:0] vel_x, vel_y, vel_z, b_x, b_y, b_z;
	logic [30:0] elem_volume, quad_area;
	logic last_node;
	logic strobe;
	logic [1:0] row, col, error_code;
	logic signed [31:0] grad_value, sym_part, antisym_part, divergence;
	logic last_entry;

	grad_scoreboard sb;
	int unsigned idle_pct;
	int unsigned sent;

	element_velocity_gradient DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("element_velocity_gradient: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		entry_t a;
		if (arst_n && strobe) begin
			a.row = row; a.col = col; a.grad = grad_value; a.sym = sym_part;
			a.anti = antisym_part; a.dv = divergence; a.err = error_code;
			a.last = last_entry;
			sb.check_entry(a);
		end
	end

	// hold start until the beat is taken; start stays high for a back-to-back node
	task send_node(node_t n);
		start <= 1'b1;
		vel_x <= n.vx; vel_y <= n.vy; vel_z <= n.vz;
		b_x <= n.bx; b_y <= n.by; b_z <= n.bz;
		elem_volume <= n.vol; quad_area <= n.area; last_node <= n.last;
		do @(posedge clk); while (busy);
		sb.note_node(n);
		sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task write_mode(bit m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		sb.planar = m;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function logic signed [31:0] pick_val();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			2: return 0;
			default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
		endcase
	endfunction

	function logic [30:0] pick_div();
		case ($urandom_range(9))
			0: return 0;
			1: return $urandom;
			2: return 31'h7fffffff;
			default: return $urandom_range(1, 1 << 18);
		endcase
	endfunction

	function node_t rand_node(bit last);
		node_t n;
		n.vx = pick_val(); n.vy = pick_val(); n.vz = pick_val();
		n.bx = pick_val(); n.by = pick_val(); n.bz = pick_val();
		n.vol = pick_div(); n.area = pick_div();
		n.last = last;
		return n;
	endfunction

	function node_t fixed_node(logic signed [31:0] v, logic signed [31:0] b, logic [30:0] d,
			bit last);
		node_t n;
		n.vx = v; n.vy = v; n.vz = v; n.bx = b; n.by = b; n.bz = b;
		n.vol = d; n.area = d; n.last = last;
		return n;
	endfunction

	task rand_element();
		int unsigned cnt;
		if ($urandom_range(9) < 8) cnt = sb.planar ? NODES_PER_QUAD : NODES_PER_HEX;
		else if ($urandom_range(4) == 0) cnt = $urandom_range(32, 36);
		else cnt = $urandom_range(1, 12);
		for (int i = 1; i <= cnt; i++) send_node(rand_node(i == cnt));
	endtask

	initial begin
		sb = new();
		sb.clear_element();
		sb.planar = 0;
		sb.fails = 0;
		sent = 0;
		idle_pct = 17;
		arst_n = 0;
		cfg_valid = 0; cfg_data = 0; start = 0;
		vel_x = 0; vel_y = 0; vel_z = 0; b_x = 0; b_y = 0; b_z = 0;
		elem_volume = 0; quad_area = 0; last_node = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hex with extreme values: saturating sums, unit volume
		for (int i = 1; i <= 8; i++)
			send_node(fixed_node(i[0] ? 32'sh7fffffff : 32'sh80000000,
				i[1] ? 32'sh80000000 : 32'sh7fffffff, 31'd1, i == 8));
		// single node marked last: count error
		send_node(fixed_node(32'sh10000, 32'sh20000, 31'h7fffffff, 1'b1));
		write_mode(1'b1);
		for (int i = 1; i <= 4; i++)
			send_node(fixed_node(32'sh30000 * i, -32'sh8000, 31'h10000, i == 4));
		// zero area in planar mode
		for (int i = 1; i <= 4; i++) begin
			node_t n;
			n = fixed_node(32'sh10000, 32'sh10000, 31'h10000, i == 4);
			n.area = 0;
			send_node(n);
		end
		// flip the mode halfway through an element
		write_mode(1'b0);
		send_node(fixed_node(32'sh50000, 32'sh20000, 31'h10000, 1'b0));
		send_node(fixed_node(-32'sh50000, 32'sh40000, 31'h10000, 1'b0));
		write_mode(1'b1);
		send_node(fixed_node(32'sh70000, -32'sh30000, 31'h20000, 1'b0));
		send_node(fixed_node(32'sh10000, 32'sh10000, 31'h20000, 1'b1));

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 17 : (ph == 1) ? 78 : 0;
			for (int m = 0; m < 2; m++) begin
				write_mode(m[0]);
				repeat (4) rand_element();
			end
			// let everything drain before going on
			start <= 1'b0;
			while (sb.pending.size() != 0) @(posedge clk);
			while (sent < 25 + 120 * (ph + 1)) rand_element();
		end

		drain();
		if (sb.fails == 0) begin
			$display("element_velocity_gradient: match");
		end else begin
			$display("element_velocity_gradient: mismatch");
		end
		$finish;
	end

endmodule

### element_velocity_gradient.f
hw/rtl/evg_pkg.sv
hw/rtl/evg_lane.sv
hw/rtl/evg_radial.sv
hw/rtl/element_velocity_gradient.sv
dv/element_velocity_gradient_tb.sv
